FILE: design/smma_pkg.sv
// Shared types and constants for the square matrix multiply-accumulate core.
// No dependencies; every other file imports this package.
package smma_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	// exact sum of up to 64 Q32.32 products plus the scaled C value
	localparam int ACC_W  = 72;

	localparam int KIND_W = 3;
	localparam int IDX_W  = 4;
	localparam int SIZE_W = 5;

	localparam logic [KIND_W-1:0] KIND_LOAD_A  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD_C  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ_C  = 3'd4;

	localparam logic STATUS_READ = 1'b0;
	localparam logic STATUS_DONE = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MATRIX_SIZE = 1'b0;

	// one read issue of the shared multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
	} smma_iss_t;

endpackage

FILE: design/smma_if.sv
// Request and response channel interfaces for the matrix multiply-accumulate core.
// Depends on smma_pkg for field widths.
interface smma_cmd_if import smma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [IDX_W-1:0]         row;
	logic [IDX_W-1:0]         col;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, kind, row, col, value, input ready);
	modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface smma_rsp_if import smma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [DATA_W-1:0] data;

	modport source (output valid, status, data, input ready);
	modport sink   (input valid, status, data, output ready);
endinterface

FILE: design/smma_mac.sv
// Shared multiply-accumulate unit: registered 32x32 multiply, 72-bit accumulator,
// shift and saturate of the finished sum. Depends on smma_pkg.
module smma_mac import smma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  smma_iss_t         iss,
	input  logic [DATA_W-1:0] a_data,
	input  logic [DATA_W-1:0] b_data,
	input  logic [DATA_W-1:0] c_data,
	output logic [DATA_W-1:0] result
);

	smma_iss_t                iss_s1;
	logic                     mac_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic        [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] a_ext;
	logic signed [DATA_W-1:0] b_ext;
	logic [ACC_W-DATA_W-FRAC_W:0] acc_hi;

	assign a_ext = $signed(a_data);
	assign b_ext = $signed(b_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			mac_s2 <= 1'b0;
		end else begin
			iss_s1 <= iss;
			mac_s2 <= iss_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_ext * b_ext;
		// load C scaled to Q32.32 with the first operand pair, then add products
		if (iss_s1.valid && iss_s1.first) begin
			acc_q <= {{(ACC_W-DATA_W-FRAC_W){c_data[DATA_W-1]}}, c_data, {FRAC_W{1'b0}}};
		end else if (mac_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	assign acc_hi = acc_q[ACC_W-1:DATA_W+FRAC_W-1];

	always_comb begin
		if ((&acc_hi) || !(|acc_hi)) begin
			result = acc_q[DATA_W+FRAC_W-1:FRAC_W];
		end else if (acc_q[ACC_W-1]) begin
			result = SAT_MIN;
		end else begin
			result = SAT_MAX;
		end
	end

	a_init_not_during_add: assert property (@(posedge clk) disable iff (!arst_n)
		!(iss_s1.valid && iss_s1.first && mac_s2))
		else $error("accumulator init collides with a pending product");

endmodule

FILE: design/smma_seq.sv
// Sequencer for the compute request: walks rows, columns and the inner index,
// drives the store read addresses and the write-back. Depends on smma_pkg.
module smma_seq import smma_pkg::*; #(
	parameter int MAX_DIM = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [SIZE_W-1:0]                     matrix_size,
	input  logic                                  done_ack,
	output smma_iss_t                             iss,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    c_addr,
	output logic                                  wb_en,
	output logic                                  done_req,
	output logic                                  busy
);

	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int IW     = $clog2(MAX_DIM);
	localparam int NW     = $clog2(MAX_DIM + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_WB,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   n_q;
	logic [IW-1:0]   i_q;
	logic [IW-1:0]   j_q;
	logic [IW-1:0]   k_q;
	logic [NW-1:0]   n_eff;
	logic            i_last;
	logic            j_last;
	logic            k_last;

	assign n_eff  = (32'(matrix_size) > MAX_DIM) ? NW'(MAX_DIM) : NW'(matrix_size);
	assign i_last = (NW'(i_q) + NW'(1)) == n_q;
	assign j_last = (NW'(j_q) + NW'(1)) == n_q;
	assign k_last = (NW'(k_q) + NW'(1)) == n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n_eff;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= (n_eff == '0) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN1;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_WB;
				ST_WB: begin
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_ISSUE;
						end
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (done_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign iss.valid = (state_q == ST_ISSUE);
	assign iss.first = (k_q == '0);
	assign wb_en     = (state_q == ST_WB);
	assign done_req  = (state_q == ST_DONE);
	assign busy      = (state_q != ST_IDLE);

	assign a_addr = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
	assign b_addr = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));
	assign c_addr = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));

	a_inner_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		iss.valid |-> (NW'(k_q) < n_q))
		else $error("inner index ran past the matrix size");

endmodule

FILE: design/square_matrix_multiply_accumulate_core.sv
// Square matrix multiply-accumulate core, C = C + A*B on signed Q16.16 matrices
// of up to MAX_DIM rows and columns (n set by the matrix_size register). Load
// requests write one element of A, B or C and are taken every cycle while no
// compute runs and no read result is held back; a read request latches its C
// element and presents it through the response register once that is free. A
// compute request holds ready low until it completes, and the completion response
// appears as ready returns: one shared 32x32 multiplier and 72-bit accumulator
// handle one product per cycle, with the DRAIN1 and DRAIN2 states and a write-back
// state per C element for pipeline drain, and a done state to hand off completion.
// Depends on smma_pkg, smma_if, smma_mac and smma_seq.
module square_matrix_multiply_accumulate_core import smma_pkg::*; #(
	parameter int MAX_DIM = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	smma_cmd_if.sink              cmd,
	smma_rsp_if.source            resp
);

	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;

	logic [SIZE_W-1:0] size_q;

	logic [DATA_W-1:0] a_mem [DEPTH];
	logic [DATA_W-1:0] b_mem [DEPTH];
	logic [DATA_W-1:0] c_mem [DEPTH];
	logic [DATA_W-1:0] a_rdata_q;
	logic [DATA_W-1:0] b_rdata_q;
	logic [DATA_W-1:0] c_rdata_q;

	logic              rd_pend_q;
	logic              rd_zero_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [DATA_W-1:0] out_data_q;

	logic              cmd_acc;
	logic              in_store;
	logic [ADDR_W-1:0] cmd_addr;
	logic              out_free;
	logic              rd_req;
	logic              a_we;
	logic              b_we;
	logic              c_we;
	logic [ADDR_W-1:0] c_waddr;
	logic [DATA_W-1:0] c_wdata;
	logic [ADDR_W-1:0] c_raddr;

	smma_iss_t         iss;
	logic [ADDR_W-1:0] seq_a_addr;
	logic [ADDR_W-1:0] seq_b_addr;
	logic [ADDR_W-1:0] seq_c_addr;
	logic              wb_en;
	logic              done_req;
	logic              done_ack;
	logic              busy;
	logic [DATA_W-1:0] mac_result;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// request decode
	assign out_free  = !out_valid_q || resp.ready;
	assign cmd.ready = !busy && !(rd_pend_q && !out_free);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign in_store  = (32'(cmd.row) < MAX_DIM) && (32'(cmd.col) < MAX_DIM);
	assign cmd_addr  = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col));

	assign rd_req = cmd_acc && cmd.kind == KIND_READ_C && in_store;
	assign a_we   = cmd_acc && cmd.kind == KIND_LOAD_A && in_store;
	assign b_we   = cmd_acc && cmd.kind == KIND_LOAD_B && in_store;
	assign c_we   = (cmd_acc && cmd.kind == KIND_LOAD_C && in_store) || wb_en;

	assign c_waddr = wb_en ? seq_c_addr : cmd_addr;
	assign c_wdata = wb_en ? mac_result : cmd.value;
	assign c_raddr = iss.valid ? seq_c_addr : cmd_addr;

	// element stores
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[cmd_addr] <= cmd.value;
		end
		if (iss.valid) begin
			a_rdata_q <= a_mem[seq_a_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[cmd_addr] <= cmd.value;
		end
		if (iss.valid) begin
			b_rdata_q <= b_mem[seq_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
		if (iss.valid || rd_req) begin
			c_rdata_q <= c_mem[c_raddr];
		end
	end

	smma_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cmd_acc && cmd.kind == KIND_COMPUTE),
		.matrix_size (size_q),
		.done_ack    (done_ack),
		.iss         (iss),
		.a_addr      (seq_a_addr),
		.b_addr      (seq_b_addr),
		.c_addr      (seq_c_addr),
		.wb_en       (wb_en),
		.done_req    (done_req),
		.busy        (busy)
	);

	smma_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.iss    (iss),
		.a_data (a_rdata_q),
		.b_data (b_rdata_q),
		.c_data (c_rdata_q),
		.result (mac_result)
	);

	// response register; a pending read goes ahead of the completion response
	assign done_ack = out_free && !rd_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			rd_zero_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_acc && cmd.kind == KIND_READ_C) begin
				rd_pend_q <= 1'b1;
				rd_zero_q <= !in_store;
			end else if (rd_pend_q && out_free) begin
				rd_pend_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= rd_pend_q || done_req;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (rd_pend_q) begin
				out_status_q <= STATUS_READ;
				out_data_q   <= rd_zero_q ? '0 : c_rdata_q;
			end else begin
				out_status_q <= STATUS_DONE;
				out_data_q   <= '0;
			end
		end
	end

	assign resp.valid  = out_valid_q;
	assign resp.status = out_status_q;
	assign resp.data   = out_data_q;

	a_stalled_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_q && !out_free) |-> !cmd.ready)
		else $error("request taken while a read result has nowhere to go");

	a_wb_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en || iss.valid) |-> !cmd.ready)
		else $error("store port shared with a request during compute");

	a_done_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && resp.status == STATUS_DONE) |-> (resp.data == '0))
		else $error("completion response carries nonzero data");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for square_matrix_multiply_accumulate_core: loads, computes
// and reads C = C + A*B over several matrix sizes and checks every response.
// Depends on smma_pkg, smma_if and the core itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import smma_pkg::*;

	localparam int DIM = 16;
	localparam int WIDE_W = 80;
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam logic [APB_ADDR_W-1:0] SIZE_ADDR = APB_ADDR_W'(4 * REG_MATRIX_SIZE);
	localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
	} mm_request_t;

	typedef struct {
		logic              status;
		logic [DATA_W-1:0] data;
	} c_response_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic pready;

	smma_cmd_if cmd_ch ();
	smma_rsp_if rsp_ch ();

	square_matrix_multiply_accumulate_core #(.MAX_DIM(DIM)) dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cmd(cmd_ch), .resp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the block's stores and register
	logic signed [DATA_W-1:0] a_mirror [DIM*DIM];
	logic signed [DATA_W-1:0] b_mirror [DIM*DIM];
	logic signed [DATA_W-1:0] c_mirror [DIM*DIM];
	logic [SIZE_W-1:0] mirror_size;

	mm_request_t requests_to_send [$];
	c_response_t responses_due [$];
	mm_request_t next_req;
	c_response_t want;

	// which store entries the stimulus has written so far (A, B, C)
	bit loaded [3][DIM*DIM];
	int queued_total = 0;
	int fault_count = 0;
	int gap_pct = 0, stall_pct = 0;
	bit calm = 1'b0;
	int gap_left = 0, stall_left = 0;

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function automatic logic [DATA_W-1:0] mac_element(input int r, input int c, input int n);
		logic signed [WIDE_W-1:0] acc;
		logic signed [WIDE_W-1:0] scaled;
		longint prod;
		acc = c_mirror[r*DIM + c];
		acc = acc <<< FRAC_W;
		for (int k = 0; k < n; k++) begin
			prod = longint'(a_mirror[r*DIM + k]) * longint'(b_mirror[k*DIM + c]);
			acc += prod;
		end
		scaled = acc >>> FRAC_W;
		if (scaled[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){scaled[WIDE_W-1]}})
			return scaled[WIDE_W-1] ? SAT_MIN : SAT_MAX;
		return scaled[DATA_W-1:0];
	endfunction

	task automatic track_request(input mm_request_t req);
		int idx;
		int n;
		idx = req.row * DIM + req.col;
		n = (mirror_size > DIM) ? DIM : mirror_size;
		case (req.kind)
			KIND_LOAD_A: a_mirror[idx] = req.value;
			KIND_LOAD_B: b_mirror[idx] = req.value;
			KIND_LOAD_C: c_mirror[idx] = req.value;
			KIND_COMPUTE: begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++)
						c_mirror[i*DIM + j] = mac_element(i, j, n);
				responses_due.push_back(c_response_t'{STATUS_DONE, '0});
			end
			KIND_READ_C: responses_due.push_back(c_response_t'{STATUS_READ, c_mirror[idx]});
			default: ;
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.kind  <= KIND_LOAD_A;
			cmd_ch.row   <= '0;
			cmd_ch.col   <= '0;
			cmd_ch.value <= '0;
			gap_left = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				track_request('{cmd_ch.kind, cmd_ch.row, cmd_ch.col, cmd_ch.value});
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_ch.valid <= 1'b0;
				end else if (requests_to_send.size() == 0) begin
					cmd_ch.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(1, 6) - 1;
					cmd_ch.valid <= 1'b0;
				end else begin
					next_req = requests_to_send.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.kind  <= next_req.kind;
					cmd_ch.row   <= next_req.row;
					cmd_ch.col   <= next_req.col;
					cmd_ch.value <= next_req.value;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (responses_due.size() == 0) begin
					flag_fault($sformatf("response with none pending: status %0b data %h",
						rsp_ch.status, rsp_ch.data));
				end else begin
					want = responses_due.pop_front();
					if (rsp_ch.status !== want.status)
						flag_fault($sformatf("status: expected %0b, got %0b",
							want.status, rsp_ch.status));
					if (rsp_ch.data !== want.data)
						flag_fault($sformatf("data: expected %h, got %h",
							want.data, rsp_ch.data));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 6) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= SIZE_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_size(input logic [SIZE_W-1:0] size);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd !== APB_DATA_W'(size))
			flag_fault($sformatf("matrix_size readback: expected %h, got %h", size, rd));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (requests_to_send.size() != 0 || cmd_ch.valid || responses_due.size() != 0);
	endtask

	task automatic next_phase(input logic [SIZE_W-1:0] size);
		logic [APB_DATA_W-1:0] rd;
		// hold until every response is in, then let any trailing load settle
		wait_drained();
		repeat (8) @(posedge clk);
		apb_access(1'b1, APB_DATA_W'(size), rd);
		mirror_size = size;
		check_size(size);
		@(negedge clk);
		gap_pct   = 10 * $urandom_range(0, 4);
		stall_pct = 10 * $urandom_range(0, 4);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return '0;
			3, 4, 5: return int'($urandom_range(0, 2**19)) - 2**18;
			default: return $urandom;
		endcase
	endfunction

	// zero means anywhere in the stores
	function automatic int pick_index(input int n);
		return (n == 0) ? $urandom_range(0, DIM-1) : $urandom_range(0, n-1);
	endfunction

	task automatic queue_request(input logic [KIND_W-1:0] kind, input int r, input int c,
			input logic [DATA_W-1:0] v);
		if (kind <= KIND_LOAD_C)
			loaded[kind - KIND_LOAD_A][r*DIM + c] = 1'b1;
		requests_to_send.push_back('{kind, IDX_W'(r), IDX_W'(c), v});
		queued_total++;
	endtask

	task automatic ensure_loaded(input int n);
		for (int m = 0; m < 3; m++)
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++)
					if (!loaded[m][r*DIM + c])
						queue_request(KIND_W'(KIND_LOAD_A + m), r, c, pick_value());
	endtask

	task automatic queue_compute(input int n);
		ensure_loaded(n);
		queue_request(KIND_COMPUTE, pick_index(0), pick_index(0), $urandom);
	endtask

	task automatic queue_read(input int r, input int c);
		if (!loaded[KIND_LOAD_C - KIND_LOAD_A][r*DIM + c])
			queue_request(KIND_LOAD_C, r, c, pick_value());
		queue_request(KIND_READ_C, r, c, $urandom);
	endtask

	task automatic gen_phase(input int n, input int count);
		int target;
		int k;
		target = queued_total + count;
		while (queued_total < target) begin
			if ($urandom_range(0, 9) < 7) begin
				// load some entries inside the active size, compute, read results back
				k = $urandom_range(1, 6);
				repeat (k)
					queue_request(KIND_W'(KIND_LOAD_A + $urandom_range(0, 2)),
						pick_index(n), pick_index(n), pick_value());
				queue_compute(n);
				k = $urandom_range(1, 6);
				repeat (k) queue_read(pick_index(n), pick_index(n));
			end else begin
				k = $urandom_range(1, 6);
				repeat (k)
					case ($urandom_range(0, 5))
						0, 1: queue_request(KIND_W'(KIND_LOAD_A + $urandom_range(0, 2)),
							pick_index(0), pick_index(0), pick_value());
						2: queue_read(pick_index(0), pick_index(0));
						3: queue_request(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
							pick_index(0), pick_index(0), $urandom);
						4: queue_compute(n);
						default: queue_read(pick_index(n), pick_index(n));
					endcase
			end
		end
	endtask

	initial begin
		int sizes [11] = '{1, 0, 3, 5, 8, 31, 4, 2, 7, 6, 16};
		int n;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind  = KIND_LOAD_A;
		cmd_ch.row   = '0;
		cmd_ch.col   = '0;
		cmd_ch.value = '0;
		rsp_ch.ready = 1'b0;
		mirror_size  = SIZE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		check_size(SIZE_RESET);
		@(negedge clk);

		// full-size pass at the reset size: fill every store, compute, sample C
		ensure_loaded(DIM);
		queue_compute(DIM);
		repeat (4) queue_read(pick_index(DIM), pick_index(DIM));

		// directed 2x2: saturation both ways, floor rounding, spare kinds
		next_phase(5'd2);
		queue_request(KIND_LOAD_A, 0, 0, SAT_MAX);
		queue_request(KIND_LOAD_A, 0, 1, SAT_MAX);
		queue_request(KIND_LOAD_A, 1, 0, 32'hFFFF_FFFF);
		queue_request(KIND_LOAD_A, 1, 1, Q_ONE);
		queue_request(KIND_LOAD_B, 0, 0, SAT_MAX);
		queue_request(KIND_LOAD_B, 0, 1, SAT_MIN);
		queue_request(KIND_LOAD_B, 1, 0, 32'h0000_0001);
		queue_request(KIND_LOAD_B, 1, 1, -Q_ONE);
		queue_request(KIND_LOAD_C, 0, 0, '0);
		queue_request(KIND_LOAD_C, 0, 1, SAT_MIN);
		queue_request(KIND_LOAD_C, 1, 0, 32'h0000_0003);
		queue_request(KIND_LOAD_C, 1, 1, SAT_MAX);
		queue_request(KIND_COMPUTE, 0, 0, '0);
		queue_read(0, 0);
		queue_read(0, 1);
		queue_read(1, 0);
		queue_read(1, 1);
		queue_read(DIM-1, DIM-1);
		queue_request(KIND_SPARE_FIRST, 0, 0, SAT_MAX);
		queue_request(KIND_SPARE_LAST, DIM-1, DIM-1, SAT_MIN);
		queue_request(KIND_COMPUTE, DIM-1, DIM-1, SAT_MIN);
		queue_read(1, 0);

		foreach (sizes[p]) begin
			next_phase(SIZE_W'(sizes[p]));
			n = (sizes[p] > DIM) ? DIM : sizes[p];
			calm = (p == $size(sizes) - 1);
			gen_phase(n, (n == DIM) ? 25 : 100);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fault_count == 0 && responses_due.size() == 0)
			$display("** square_matrix_multiply_accumulate_core: PASSED **");
		else
			$display("** square_matrix_multiply_accumulate_core: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** square_matrix_multiply_accumulate_core: FAILED **");
		$finish;
	end

endmodule
